// ===== rtl/plc_pkg.sv =====
// plc_pkg: shared types and codes for the positional list engine
// holds request modes, result status codes, controller states and the cell control struct
// no dependencies
package plc_pkg;

	// width of a zero-based slot index handed down the cell row
	localparam int SLOT_W = 8;

	// request modes
	typedef enum logic [2:0] {
		MD_HEAD   = 3'd0,
		MD_TAIL   = 3'd1,
		MD_INSERT = 3'd2,
		MD_DELETE = 3'd3,
		MD_LOCATE = 3'd4,
		MD_GET    = 3'd5,
		MD_CLEAR  = 3'd6
	} mode_t;

	// result status codes
	typedef enum logic [1:0] {
		STS_DONE  = 2'd0,
		STS_RANGE = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	// controller states
	typedef enum logic {
		FSM_RUN  = 1'b0,
		FSM_SCAN = 1'b1
	} fsm_state_t;

	// control broadcast to every cell of the row
	typedef struct packed {
		logic              ins;
		logic              del;
		logic              cmp;
		logic [SLOT_W-1:0] slot;
	} cell_ctrl_t;

endpackage

// ===== rtl/plc_cell.sv =====
// plc_cell: one storage cell of the list row
// shifts toward its neighbors on insert and delete, registers a compare hit on locate
// depends on plc_pkg
module plc_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  plc_pkg::cell_ctrl_t   ctrl,
	input  logic [DATA_WIDTH-1:0] din,
	input  logic [DATA_WIDTH-1:0] prev_val,
	input  logic [DATA_WIDTH-1:0] next_val,
	output logic [DATA_WIDTH-1:0] val,
	output logic                  hit
);

	localparam logic [plc_pkg::SLOT_W-1:0] MyIdx = plc_pkg::SLOT_W'(INDEX);

	logic [DATA_WIDTH-1:0] val_q;
	logic                  hit_q;
	logic                  at_or_after;

	assign at_or_after = (MyIdx >= ctrl.slot);

	// value register: open a gap at the slot or close one over it
	always_ff @(posedge clk) begin
		if (ctrl.ins && at_or_after) begin
			val_q <= (MyIdx == ctrl.slot) ? din : prev_val;
		end else if (ctrl.del && at_or_after) begin
			val_q <= next_val;
		end
	end

	// compare hit, used by the scan cycle of a locate
	always_ff @(posedge clk) begin
		if (ctrl.cmp) begin
			hit_q <= (val_q == din);
		end
	end

	assign val = val_q;
	assign hit = hit_q;

endmodule

// ===== rtl/positional_list_engine.sv =====
// positional_list_engine: top level of the ordered list with 1-based positions
// a row of plc_cell instances plus fill counter, request decode and result registers
// depends on plc_pkg and plc_cell
//
// Usage
//   Request channel: drive mode, position and value with start high; the
//   request is taken at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle and status, data_out,
//   found_at and count are valid in that cycle; results cannot be held off.
// Latency and throughput
//   Head, tail, insert, delete, get, clear and the unused mode: done rises
//   in the cycle right after the request; busy stays low, so one request per
//   cycle unless a locate holds busy high. Locate: the cells register their
//   compare hits on the request edge, then one scan cycle picks the first
//   hit; busy is high for that cycle and done follows it.
// Reset
//   arst_n low empties the list at once (fill cleared, no busy, no done);
//   cell contents are undefined until written and are never read before.
// Stalls
//   The receiver cannot stall, so no result buffering exists.
module positional_list_engine #(
	parameter int DEPTH      = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [7:0]  position,
	input  logic [31:0] value,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] data_out,
	output logic [5:0]  found_at,
	output logic [5:0]  count
);

	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W  = ((FILL_W > 8) ? FILL_W : 8) + 1;

	plc_pkg::fsm_state_t   state_q, state_n;
	logic [FILL_W-1:0]     fill_q, fill_n;
	logic                  go;
	logic                  to_scan;
	plc_pkg::cell_ctrl_t   ctrl;
	logic [DATA_WIDTH-1:0] vin;
	logic [DATA_WIDTH-1:0] cell_val [DEPTH];
	logic [DEPTH-1:0]      cell_hit;
	logic [DATA_WIDTH-1:0] rd_val;
	logic [7:0]            pos_m1;
	logic [CMP_W-1:0]      pos_x, fill_x;
	logic                  full;
	logic                  in_get_range, in_ins_range;
	plc_pkg::status_t      sts_n;
	logic [DATA_WIDTH-1:0] dat_n;
	logic [FILL_W-1:0]     found;

	logic                  done_q;
	plc_pkg::status_t      status_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [FILL_W-1:0]     found_q;
	logic [FILL_W-1:0]     count_q;

	assign go     = start && !busy;
	assign vin    = DATA_WIDTH'(value);
	assign pos_m1 = position - 8'd1;
	assign pos_x  = CMP_W'(position);
	assign fill_x = CMP_W'(fill_q);
	assign full   = (fill_q == FILL_W'(DEPTH));
	assign rd_val = cell_val[pos_m1[IDX_W-1:0]];

	assign in_get_range = (pos_x != '0) && (pos_x <= fill_x);
	assign in_ins_range = (pos_x != '0) && (pos_x <= fill_x + CMP_W'(1));

	// cell row: each cell talks to its neighbors; vin and self stand in at the ends
	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_v, next_v;
		if (gi == 0) begin : g_first
			assign prev_v = vin;
		end else begin : g_mid
			assign prev_v = cell_val[gi-1];
		end
		if (gi == DEPTH - 1) begin : g_last
			assign next_v = cell_val[gi];
		end else begin : g_next
			assign next_v = cell_val[gi+1];
		end
		plc_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.INDEX     (gi)
		) u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.din     (vin),
			.prev_val(prev_v),
			.next_val(next_v),
			.val     (cell_val[gi]),
			.hit     (cell_hit[gi])
		);
	end

	// request decode: cell control, fill update and immediate result
	always_comb begin
		ctrl    = '0;
		fill_n  = fill_q;
		sts_n   = plc_pkg::STS_DONE;
		dat_n   = '0;
		to_scan = 1'b0;
		unique case (mode) inside
			plc_pkg::MD_HEAD, plc_pkg::MD_TAIL: begin
				if (full) begin
					sts_n = plc_pkg::STS_FULL;
				end else begin
					ctrl.ins  = go;
					ctrl.slot = (mode == plc_pkg::MD_HEAD) ? '0 :
						plc_pkg::SLOT_W'(fill_q);
					fill_n    = fill_q + FILL_W'(1);
				end
			end
			plc_pkg::MD_INSERT: begin
				if (!in_ins_range) begin
					sts_n = plc_pkg::STS_RANGE;
				end else if (full) begin
					sts_n = plc_pkg::STS_FULL;
				end else begin
					ctrl.ins  = go;
					ctrl.slot = pos_m1;
					fill_n    = fill_q + FILL_W'(1);
				end
			end
			plc_pkg::MD_DELETE: begin
				if (!in_get_range) begin
					sts_n = plc_pkg::STS_RANGE;
				end else begin
					ctrl.del  = go;
					ctrl.slot = pos_m1;
					dat_n     = rd_val;
					fill_n    = fill_q - FILL_W'(1);
				end
			end
			plc_pkg::MD_LOCATE: begin
				ctrl.cmp = go;
				to_scan  = 1'b1;
			end
			plc_pkg::MD_GET: begin
				if (!in_get_range) begin
					sts_n = plc_pkg::STS_RANGE;
				end else begin
					dat_n = rd_val;
				end
			end
			plc_pkg::MD_CLEAR: begin
				fill_n = '0;
			end
			default: begin
				fill_n = fill_q;
			end
		endcase
	end

	// first registered hit below the fill mark
	always_comb begin
		found = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (cell_hit[i] && (FILL_W'(i) < fill_q)) begin
				found = FILL_W'(i + 1);
			end
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			plc_pkg::FSM_RUN:  if (go && to_scan) state_n = plc_pkg::FSM_SCAN;
			plc_pkg::FSM_SCAN: state_n = plc_pkg::FSM_RUN;
			default:           state_n = plc_pkg::FSM_RUN;
		endcase
	end

	// state outputs
	always_comb begin
		busy = (state_q == plc_pkg::FSM_SCAN);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plc_pkg::FSM_RUN;
			fill_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (go) begin
				fill_q <= fill_n;
			end
			done_q <= (go && !to_scan) || busy;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (busy) begin
			status_q <= plc_pkg::STS_DONE;
			data_q   <= '0;
			found_q  <= found;
			count_q  <= fill_q;
		end else if (go) begin
			status_q <= sts_n;
			data_q   <= dat_n;
			found_q  <= '0;
			count_q  <= fill_n;
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign data_out = 32'(data_q);
	assign found_at = 6'(found_q);
	assign count    = 6'(count_q);

endmodule

// ===== rtl/plc_check.sv =====
// plc_check: port-level assertions for the positional list engine
// bound to positional_list_engine; depends on plc_pkg
module plc_check #(
	parameter int DEPTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [2:0]  mode,
	input logic        done,
	input logic [1:0]  status,
	input logic [31:0] data_out,
	input logic [5:0]  found_at,
	input logic [5:0]  count
);

	// every non-locate request answers in the next cycle
	a_fast_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode != plc_pkg::MD_LOCATE) |=> done)
		else $error("request not answered in next cycle");

	// a locate scans for one busy cycle, then answers
	a_locate: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == plc_pkg::MD_LOCATE) |=> (busy && !done) ##1 done)
		else $error("locate timing broken");

	// no result without a request or a scan before it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(busy)))
		else $error("result without request");

	// a full report means the list holds DEPTH entries
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == plc_pkg::STS_FULL) |-> (count == 6'(DEPTH)))
		else $error("full status with short list");

	// a hit position comes with a clean status and no data
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found_at != 6'd0) |-> (status == plc_pkg::STS_DONE && data_out == 32'd0))
		else $error("locate result mixed with other fields");

endmodule

bind positional_list_engine plc_check #(
	.DEPTH(DEPTH)
) u_plc_check (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.mode    (mode),
	.done    (done),
	.status  (status),
	.data_out(data_out),
	.found_at(found_at),
	.count   (count)
);
